// File: rtl/core/grid_robot_stack_machine_defines.svh
// Assertion macros for the grid robot stack machine.
`ifndef GRID_ROBOT_STACK_MACHINE_DEFINES_SVH
`define GRID_ROBOT_STACK_MACHINE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define GRSM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define GRSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/grsm_pkg.sv
`default_nettype none

package grsm_pkg;

   // Grid geometry (fixed by the coordinate fields)
   localparam int GRID_SIZE = 8;
   localparam int COORD_W   = 3;
   localparam int MAP_DEPTH = GRID_SIZE * GRID_SIZE;
   localparam int MAP_AW    = 2 * COORD_W;

   // Defaults for the top level parameters
   localparam int DEF_PROG_DEPTH  = 256;
   localparam int DEF_STACK_DEPTH = 16;

   localparam int CMD_W    = 5;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_START         = 5'd0,
      CMD_MOVE          = 5'd1,
      CMD_TURN_LEFT     = 5'd2,
      CMD_FRONT_BLOCKED = 5'd3,
      CMD_NOT           = 5'd4,
      CMD_PUSH          = 5'd5,
      CMD_POP           = 5'd6,
      CMD_AND           = 5'd7,
      CMD_OR            = 5'd8,
      CMD_JZ            = 5'd9,
      CMD_JMP           = 5'd10,
      CMD_PUSHCOUNT     = 5'd11,
      CMD_POPCOUNT      = 5'd12,
      CMD_JCE           = 5'd13,
      CMD_INC           = 5'd14,
      CMD_END           = 5'd15,
      CMD_LOAD_CELL     = 5'd16
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_BLOCKED   = 3'd1,
      STAT_OVERFLOW  = 3'd2,
      STAT_UNDERFLOW = 3'd3,
      STAT_PC_RANGE  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      HEAD_TOP    = 2'd0,
      HEAD_LEFT   = 2'd1,
      HEAD_BOTTOM = 2'd2,
      HEAD_RIGHT  = 2'd3
   } heading_type;

   // Bit positions in a wall map entry
   localparam logic [1:0] WALL_TOP    = 2'd0;
   localparam logic [1:0] WALL_BOTTOM = 2'd1;
   localparam logic [1:0] WALL_LEFT   = 2'd2;
   localparam logic [1:0] WALL_RIGHT  = 2'd3;

   // Stack control and status between the core and a stack
   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } stack_ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } stack_stat_type;

endpackage

`default_nettype wire

// File: rtl/core/grsm_stack.sv
`default_nettype none

// LIFO held in a synchronous memory. The top entry is fetched ahead from
// the next depth, so it is ready for the following word.
module grsm_stack #(
   parameter int WIDTH = 1,
   parameter int DEPTH = grsm_pkg::DEF_STACK_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire grsm_pkg::stack_ctrl_type ctrl,
   input  wire logic [WIDTH-1:0]         push_data,
   output logic [WIDTH-1:0]              top_data,
   output grsm_pkg::stack_stat_type      stat
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] top_ff;
   logic [DW-1:0]    depth_ff, depth_in;
   logic [DW-1:0]    rd_idx;
   logic [AW-1:0]    rd_addr, wr_addr;

   // Next depth
   always_comb begin
      depth_in = depth_ff;
      if (ctrl.clear) begin
         depth_in = '0;
      end else if (ctrl.push) begin
         depth_in = depth_ff + DW'(1);
      end else if (ctrl.pop) begin
         depth_in = depth_ff - DW'(1);
      end
   end

   // Top of the next depth; empty stack reads entry 0 (unused)
   assign rd_idx  = depth_in - DW'(1);
   assign rd_addr = (depth_in == '0) ? '0 : rd_idx[AW-1:0];
   assign wr_addr = depth_ff[AW-1:0];

   // Memory port; a push forwards its word straight to the top register
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem_ff[wr_addr] <= push_data;
      end
      top_ff <= ctrl.push ? push_data : mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   assign top_data   = top_ff;
   assign stat.empty = (depth_ff == '0);
   assign stat.full  = (depth_ff == DW'(DEPTH));

endmodule

`default_nettype wire

// File: rtl/core/grid_robot_stack_machine.sv
// A result word is registered in the cycle after its instruction is taken.
// Throughput: 1 instruction per cycle unless a held result stalls the input;
// the wall map and both stacks prefetch from the next robot state; no bubble.
// Reset clears robot state, pc, counter and both stack depths; the wall
// map's 64 valid bits clear in the same cycle, so no clearing pass runs.
`default_nettype none
`include "grid_robot_stack_machine_defines.svh"

module grid_robot_stack_machine #(
   parameter int PROG_DEPTH  = grsm_pkg::DEF_PROG_DEPTH,
   parameter int STACK_DEPTH = grsm_pkg::DEF_STACK_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // instruction channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [grsm_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic signed [7:0]             req_offset,
   input  wire logic [grsm_pkg::COUNT_W-1:0]  req_count,
   input  wire logic [grsm_pkg::COORD_W-1:0]  req_cell_row,
   input  wire logic [grsm_pkg::COORD_W-1:0]  req_cell_col,
   input  wire logic [3:0]                    req_cell_walls,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [grsm_pkg::STATUS_W-1:0]      rsp_status,
   output logic [grsm_pkg::COORD_W-1:0]       rsp_robot_row,
   output logic [grsm_pkg::COORD_W-1:0]       rsp_robot_col,
   output logic [1:0]                         rsp_heading,
   output logic                               rsp_acc_bit,
   output logic [grsm_pkg::COUNT_W-1:0]       rsp_loop_count,
   output logic [7:0]                         rsp_prog_counter
);

   localparam int CW = grsm_pkg::COORD_W;
   localparam int NW = grsm_pkg::COUNT_W;
   localparam int AW = grsm_pkg::MAP_AW;
   localparam int PW = $clog2(PROG_DEPTH);
   localparam int TW = ((PW > 8) ? PW : 8) + 2;

   // Cell in front of the robot
   typedef struct packed {
      logic          at_edge;
      logic [CW-1:0] row;
      logic [CW-1:0] col;
      logic [1:0]    side;
   } front_type;

   function automatic front_type front_of(input logic [CW-1:0] row,
                                          input logic [CW-1:0] col,
                                          input logic [1:0]    hdg);
      front_type f;
      f.at_edge = 1'b0;
      f.row     = row;
      f.col     = col;
      f.side    = grsm_pkg::WALL_TOP;
      case (grsm_pkg::heading_type'(hdg))
         grsm_pkg::HEAD_TOP: begin
            f.at_edge = (row == '0);
            f.row     = row - CW'(1);
            f.side    = grsm_pkg::WALL_BOTTOM;
         end
         grsm_pkg::HEAD_LEFT: begin
            f.at_edge = (col == '0);
            f.col     = col - CW'(1);
            f.side    = grsm_pkg::WALL_RIGHT;
         end
         grsm_pkg::HEAD_BOTTOM: begin
            f.at_edge = (row == CW'(grsm_pkg::GRID_SIZE - 1));
            f.row     = row + CW'(1);
            f.side    = grsm_pkg::WALL_TOP;
         end
         default: begin
            f.at_edge = (col == CW'(grsm_pkg::GRID_SIZE - 1));
            f.col     = col + CW'(1);
            f.side    = grsm_pkg::WALL_LEFT;
         end
      endcase
      return f;
   endfunction

   // Architectural state
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [1:0]    heading_ff, heading_in;
   logic          acc_ff, acc_in;
   logic [NW-1:0] count_ff, count_in;
   logic [PW-1:0] pc_ff, pc_in;

   // Result word register
   logic                          rsp_valid_ff;
   grsm_pkg::status_type          status_ff, status_in;
   logic [CW-1:0]                 rsp_row_ff, rsp_col_ff;
   logic [1:0]                    rsp_heading_ff;
   logic                          rsp_acc_ff;
   logic [NW-1:0]                 rsp_count_ff;
   logic [7:0]                    rsp_pc_ff;

   // Wall map memory with per-entry valid bits and a prefetch register
   logic [3:0]           wall_ff [grsm_pkg::MAP_DEPTH];
   logic [grsm_pkg::MAP_DEPTH-1:0] wall_vld_ff;
   logic [3:0]           wall_rd_ff, wall_fwd_ff;
   logic                 wall_hit_ff, wall_hit_in;
   logic                 wall_vld_rd_ff;
   logic                 wall_we;
   logic [AW-1:0]        wall_wr_addr, wall_rd_addr;
   logic [3:0]           front_walls;

   front_type            cur, pf;
   logic [CW-1:0]        pf_row, pf_col;
   logic [1:0]           pf_heading;
   logic                 front_blk;

   // Stacks
   grsm_pkg::stack_ctrl_type acc_ctl, cnt_ctl;
   grsm_pkg::stack_stat_type acc_stat, cnt_stat;
   logic                     acc_top;
   logic [NW-1:0]            cnt_top;

   // Jump target
   logic [TW-1:0]        pc_wide, jump_sum, pc_out_wide;
   logic signed [TW-1:0] off_wide;
   logic                 jump_ok;
   logic                 accept;

   // Handshake: output register stalls the input only when it is held
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Front cell of the current state and its walls
   assign cur         = front_of(row_ff, col_ff, heading_ff);
   assign front_walls = wall_hit_ff    ? wall_fwd_ff :
                        wall_vld_rd_ff ? wall_rd_ff  : 4'd0;
   assign front_blk   = cur.at_edge | front_walls[cur.side];

   // Relative jump with range check
   assign pc_wide  = TW'(pc_ff);
   assign off_wide = TW'(req_offset);
   assign jump_sum = pc_wide + $unsigned(off_wide);
   assign jump_ok  = ~jump_sum[TW-1] & (jump_sum < TW'(PROG_DEPTH));

   // Instruction execution
   always_comb begin
      row_in     = row_ff;
      col_in     = col_ff;
      heading_in = heading_ff;
      acc_in     = acc_ff;
      count_in   = count_ff;
      pc_in      = pc_ff;
      status_in  = grsm_pkg::STAT_OK;
      acc_ctl    = '0;
      cnt_ctl    = '0;
      wall_we    = 1'b0;
      if (accept) begin
         case (grsm_pkg::cmd_type'(req_cmd))
            grsm_pkg::CMD_START: begin
               row_in     = '0;
               col_in     = '0;
               heading_in = grsm_pkg::HEAD_TOP;
               acc_in     = 1'b0;
               count_in   = '0;
               pc_in      = '0;
               acc_ctl.clear = 1'b1;
               cnt_ctl.clear = 1'b1;
            end
            grsm_pkg::CMD_MOVE: begin
               if (front_blk) begin
                  status_in = grsm_pkg::STAT_BLOCKED;
               end else begin
                  row_in = cur.row;
                  col_in = cur.col;
               end
            end
            grsm_pkg::CMD_TURN_LEFT:     heading_in = heading_ff + 2'd1;
            grsm_pkg::CMD_FRONT_BLOCKED: acc_in = front_blk;
            grsm_pkg::CMD_NOT:           acc_in = ~acc_ff;
            grsm_pkg::CMD_PUSH: begin
               if (acc_stat.full) begin
                  status_in = grsm_pkg::STAT_OVERFLOW;
               end else begin
                  acc_ctl.push = 1'b1;
               end
            end
            grsm_pkg::CMD_POP: begin
               if (acc_stat.empty) begin
                  status_in = grsm_pkg::STAT_UNDERFLOW;
               end else begin
                  acc_ctl.pop = 1'b1;
               end
            end
            grsm_pkg::CMD_AND, grsm_pkg::CMD_OR: begin
               if (acc_stat.empty) begin
                  status_in = grsm_pkg::STAT_UNDERFLOW;
               end else if (req_cmd == grsm_pkg::CMD_AND) begin
                  acc_in = acc_ff & acc_top;
               end else begin
                  acc_in = acc_ff | acc_top;
               end
            end
            grsm_pkg::CMD_JZ, grsm_pkg::CMD_JMP, grsm_pkg::CMD_JCE: begin
               if ((req_cmd == grsm_pkg::CMD_JMP) ||
                   ((req_cmd == grsm_pkg::CMD_JZ) && !acc_ff) ||
                   ((req_cmd == grsm_pkg::CMD_JCE) && (count_ff == req_count))) begin
                  if (jump_ok) begin
                     pc_in = jump_sum[PW-1:0];
                  end else begin
                     status_in = grsm_pkg::STAT_PC_RANGE;
                  end
               end
            end
            grsm_pkg::CMD_PUSHCOUNT: begin
               if (cnt_stat.full) begin
                  status_in = grsm_pkg::STAT_OVERFLOW;
               end else begin
                  cnt_ctl.push = 1'b1;
                  count_in     = '0;
               end
            end
            grsm_pkg::CMD_POPCOUNT: begin
               if (cnt_stat.empty) begin
                  status_in = grsm_pkg::STAT_UNDERFLOW;
               end else begin
                  cnt_ctl.pop = 1'b1;
                  count_in    = cnt_top;
               end
            end
            grsm_pkg::CMD_INC: begin
               if (count_ff != '1) begin
                  count_in = count_ff + NW'(1);
               end
            end
            grsm_pkg::CMD_LOAD_CELL: wall_we = 1'b1;
            default: ;
         endcase
      end
   end

   // Prefetch address: front cell of the state after this cycle
   assign pf_row       = reset ? '0 : row_in;
   assign pf_col       = reset ? '0 : col_in;
   assign pf_heading   = reset ? grsm_pkg::HEAD_TOP : heading_in;
   assign pf           = front_of(pf_row, pf_col, pf_heading);
   assign wall_rd_addr = {pf.row, pf.col};
   assign wall_wr_addr = {req_cell_row, req_cell_col};
   assign wall_hit_in  = wall_we & (wall_wr_addr == wall_rd_addr);

   // Wall map memory port
   always_ff @(posedge clock) begin
      if (wall_we) begin
         wall_ff[wall_wr_addr] <= req_cell_walls;
      end
      wall_rd_ff  <= wall_ff[wall_rd_addr];
      wall_fwd_ff <= req_cell_walls;
   end

   // Wall map valid bits and read bypass control
   always_ff @(posedge clock) begin
      if (reset) begin
         wall_vld_ff    <= '0;
         wall_hit_ff    <= 1'b0;
         wall_vld_rd_ff <= 1'b0;
      end else begin
         if (wall_we) begin
            wall_vld_ff[wall_wr_addr] <= 1'b1;
         end
         wall_hit_ff    <= wall_hit_in;
         wall_vld_rd_ff <= wall_vld_ff[wall_rd_addr];
      end
   end

   grsm_stack #(
      .WIDTH (1),
      .DEPTH (STACK_DEPTH)
   ) u_acc_stack (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (acc_ctl),
      .push_data (acc_ff),
      .top_data  (acc_top),
      .stat      (acc_stat)
   );

   grsm_stack #(
      .WIDTH (NW),
      .DEPTH (STACK_DEPTH)
   ) u_cnt_stack (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (cnt_ctl),
      .push_data (count_ff),
      .top_data  (cnt_top),
      .stat      (cnt_stat)
   );

   // Machine state
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         col_ff     <= '0;
         heading_ff <= grsm_pkg::HEAD_TOP;
         acc_ff     <= 1'b0;
         count_ff   <= '0;
         pc_ff      <= '0;
      end else begin
         row_ff     <= row_in;
         col_ff     <= col_in;
         heading_ff <= heading_in;
         acc_ff     <= acc_in;
         count_ff   <= count_in;
         pc_ff      <= pc_in;
      end
   end

   // Result word register
   assign pc_out_wide = TW'(pc_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff      <= status_in;
         rsp_row_ff     <= row_in;
         rsp_col_ff     <= col_in;
         rsp_heading_ff <= heading_in;
         rsp_acc_ff     <= acc_in;
         rsp_count_ff   <= count_in;
         rsp_pc_ff      <= pc_out_wide[7:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_robot_row    = rsp_row_ff;
   assign rsp_robot_col    = rsp_col_ff;
   assign rsp_heading      = rsp_heading_ff;
   assign rsp_acc_bit      = rsp_acc_ff;
   assign rsp_loop_count   = rsp_count_ff;
   assign rsp_prog_counter = rsp_pc_ff;

   // Checks
   `GRSM_ASSERT_NEXT(a_accept_gives_word, clock, reset, accept, rsp_valid_ff, "accepted word gave no result")
   `GRSM_ASSERT_NOW(a_pc_in_range, clock, reset, 1'b1, (TW'(pc_ff) < TW'(PROG_DEPTH)), "pc out of range")
   `GRSM_ASSERT_NOW(a_no_push_when_full, clock, reset, (acc_ctl.push || cnt_ctl.push), !((acc_ctl.push && acc_stat.full) || (cnt_ctl.push && cnt_stat.full)), "push into a full stack")
   `GRSM_ASSERT_NEXT(a_count_saturates, clock, reset, (accept && (req_cmd == grsm_pkg::CMD_INC) && (count_ff == '1)), (count_ff == '1), "counter wrapped")

endmodule

`default_nettype wire

// File: sim/tb_grid_robot_stack_machine.sv
`timescale 1ns / 100ps

module tb_grid_robot_stack_machine;

   localparam int CMD_W        = grsm_pkg::CMD_W;
   localparam int COUNT_W      = grsm_pkg::COUNT_W;
   localparam int COORD_W      = grsm_pkg::COORD_W;
   localparam int STATUS_W     = grsm_pkg::STATUS_W;
   localparam int MAP_DEPTH    = grsm_pkg::MAP_DEPTH;
   localparam int GRID_SIZE    = grsm_pkg::GRID_SIZE;
   localparam int PROG_DEPTH   = grsm_pkg::DEF_PROG_DEPTH;
   localparam int STACK_DEPTH  = grsm_pkg::DEF_STACK_DEPTH;
   localparam int DIRECTED_MAX = 25;
   localparam int RANDOM_ITEMS = 1700;
   localparam int HOLD_AFTER   = 400;  // words taken before the long hold-off
   localparam int HOLD_CYCLES  = 250;
   localparam int PRINT_MAX    = 200;

   typedef struct {
      logic [CMD_W-1:0]   cmd;
      logic signed [7:0]  offset;
      logic [COUNT_W-1:0] count;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [3:0]         walls;
   } instr_word_type;

   typedef struct {
      grsm_pkg::status_type status;
      logic [COORD_W-1:0]   row;
      logic [COORD_W-1:0]   col;
      logic [1:0]           heading;
      logic                 acc;
      logic [COUNT_W-1:0]   count;
      logic [7:0]           pc;
   } robot_word_type;

   typedef enum {STALL_NONE, STALL_COIN, STALL_THIRD, STALL_RARE} stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic [CMD_W-1:0]     req_cmd        = '0;
   logic signed [7:0]    req_offset     = '0;
   logic [COUNT_W-1:0]   req_count      = '0;
   logic [COORD_W-1:0]   req_cell_row   = '0;
   logic [COORD_W-1:0]   req_cell_col   = '0;
   logic [3:0]           req_cell_walls = '0;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [COORD_W-1:0]   rsp_robot_row;
   logic [COORD_W-1:0]   rsp_robot_col;
   logic [1:0]           rsp_heading;
   logic                 rsp_acc_bit;
   logic [COUNT_W-1:0]   rsp_loop_count;
   logic [7:0]           rsp_prog_counter;

   grid_robot_stack_machine u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_offset       (req_offset),
      .req_count        (req_count),
      .req_cell_row     (req_cell_row),
      .req_cell_col     (req_cell_col),
      .req_cell_walls   (req_cell_walls),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_robot_row    (rsp_robot_row),
      .rsp_robot_col    (rsp_robot_col),
      .rsp_heading      (rsp_heading),
      .rsp_acc_bit      (rsp_acc_bit),
      .rsp_loop_count   (rsp_loop_count),
      .rsp_prog_counter (rsp_prog_counter)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Shadow copy of the robot and its stacks
   logic [3:0]         wall_map [MAP_DEPTH];
   logic [COORD_W-1:0] row_q, col_q;
   logic [1:0]         heading_q;
   logic               acc_q;
   logic               acc_stack [STACK_DEPTH];
   int                 acc_depth;
   logic [COUNT_W-1:0] count_q;
   logic [COUNT_W-1:0] count_stack [STACK_DEPTH];
   int                 count_depth;
   int                 pc_q;

   instr_word_type pending_instrs[$];
   instr_word_type cur_instr;
   robot_word_type expected_words[$];

   int error_count  = 0;
   int instrs_done  = 0;
   int results_seen = 0;
   int status_seen [8];
   bit hold_done    = 1'b0;

   task automatic report_error(input string msg);
      // cap the printout, keep counting
      if (error_count < PRINT_MAX)
         $display("%0t ns: mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] exp_v);
      if (got !== exp_v)
         report_error($sformatf("%s got %0h expected %0h", name, got, exp_v));
   endtask

   task automatic clear_machine();
      row_q = '0;
      col_q = '0;
      heading_q = grsm_pkg::HEAD_TOP;
      acc_q = 1'b0;
      count_q = '0;
      pc_q = 0;
      acc_depth = 0;
      count_depth = 0;
   endtask

   // Edge or neighbour wall facing the robot; nr/nc give the cell ahead
   function automatic logic front_closed(output logic [COORD_W-1:0] nr,
                                         output logic [COORD_W-1:0] nc);
      logic closed;
      nr = row_q;
      nc = col_q;
      closed = 1'b0;
      case (heading_q)
         grsm_pkg::HEAD_TOP: begin
            if (row_q == 0 || wall_map[{row_q - 3'd1, col_q}][grsm_pkg::WALL_BOTTOM])
               closed = 1'b1;
            else nr = row_q - 3'd1;
         end
         grsm_pkg::HEAD_LEFT: begin
            if (col_q == 0 || wall_map[{row_q, col_q - 3'd1}][grsm_pkg::WALL_RIGHT])
               closed = 1'b1;
            else nc = col_q - 3'd1;
         end
         grsm_pkg::HEAD_BOTTOM: begin
            if (row_q == 3'(GRID_SIZE - 1) ||
                wall_map[{row_q + 3'd1, col_q}][grsm_pkg::WALL_TOP])
               closed = 1'b1;
            else nr = row_q + 3'd1;
         end
         default: begin
            if (col_q == 3'(GRID_SIZE - 1) ||
                wall_map[{row_q, col_q + 3'd1}][grsm_pkg::WALL_LEFT])
               closed = 1'b1;
            else nc = col_q + 3'd1;
         end
      endcase
      return closed;
   endfunction

   // Relative jump, refused when the target leaves program memory
   task automatic take_jump(input logic signed [7:0] offset,
                            output grsm_pkg::status_type st);
      int target;
      target = pc_q + int'(offset);
      if (target < 0 || target >= PROG_DEPTH) begin
         st = grsm_pkg::STAT_PC_RANGE;
      end else begin
         pc_q = target;
         st = grsm_pkg::STAT_OK;
      end
   endtask

   // Apply one instruction to the shadow state and queue the word it gives
   task automatic execute_instr(input instr_word_type w);
      robot_word_type       res;
      logic [COORD_W-1:0]   nr, nc;
      logic                 closed;
      grsm_pkg::status_type st;
      st = grsm_pkg::STAT_OK;
      case (w.cmd)
         grsm_pkg::CMD_START: clear_machine();
         grsm_pkg::CMD_MOVE: begin
            closed = front_closed(nr, nc);
            if (closed) begin
               st = grsm_pkg::STAT_BLOCKED;
            end else begin
               row_q = nr;
               col_q = nc;
            end
         end
         grsm_pkg::CMD_TURN_LEFT: heading_q = heading_q + 2'd1;
         grsm_pkg::CMD_FRONT_BLOCKED: begin
            closed = front_closed(nr, nc);
            acc_q = closed;
         end
         grsm_pkg::CMD_NOT: acc_q = ~acc_q;
         grsm_pkg::CMD_PUSH: begin
            if (acc_depth >= STACK_DEPTH) begin
               st = grsm_pkg::STAT_OVERFLOW;
            end else begin
               acc_stack[acc_depth] = acc_q;
               acc_depth++;
            end
         end
         grsm_pkg::CMD_POP: begin
            if (acc_depth == 0) st = grsm_pkg::STAT_UNDERFLOW;
            else acc_depth--;
         end
         grsm_pkg::CMD_AND, grsm_pkg::CMD_OR: begin
            if (acc_depth == 0) st = grsm_pkg::STAT_UNDERFLOW;
            else if (w.cmd == grsm_pkg::CMD_AND) acc_q = acc_q & acc_stack[acc_depth - 1];
            else acc_q = acc_q | acc_stack[acc_depth - 1];
         end
         grsm_pkg::CMD_JZ: if (!acc_q) take_jump(w.offset, st);
         grsm_pkg::CMD_JMP: take_jump(w.offset, st);
         grsm_pkg::CMD_PUSHCOUNT: begin
            if (count_depth >= STACK_DEPTH) begin
               st = grsm_pkg::STAT_OVERFLOW;
            end else begin
               count_stack[count_depth] = count_q;
               count_depth++;
               count_q = '0;
            end
         end
         grsm_pkg::CMD_POPCOUNT: begin
            if (count_depth == 0) begin
               st = grsm_pkg::STAT_UNDERFLOW;
            end else begin
               count_depth--;
               count_q = count_stack[count_depth];
            end
         end
         grsm_pkg::CMD_JCE: if (count_q == w.count) take_jump(w.offset, st);
         grsm_pkg::CMD_INC: if (count_q != 16'hFFFF) count_q = count_q + 16'd1;
         grsm_pkg::CMD_LOAD_CELL: wall_map[{w.row, w.col}] = w.walls;
         default: ;
      endcase
      res.status  = st;
      res.row     = row_q;
      res.col     = col_q;
      res.heading = heading_q;
      res.acc     = acc_q;
      res.count   = count_q;
      res.pc      = pc_q[7:0];
      expected_words.push_back(res);
   endtask

   // Driver: bursts of words with random gaps, payload held while stalled
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin : drive_proc
      logic nxt_valid;
      if (reset) begin
         clear_machine();
         foreach (wall_map[i]) wall_map[i] = 4'h0;
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            execute_instr(cur_instr);
            instrs_done++;
         end
         if (!req_valid || !req_stall) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_instrs.size() != 0) begin
               cur_instr = pending_instrs.pop_front();
               nxt_valid = 1'b1;
               req_cmd        <= cur_instr.cmd;
               req_offset     <= cur_instr.offset;
               req_count      <= cur_instr.count;
               req_cell_row   <= cur_instr.row;
               req_cell_col   <= cur_instr.col;
               req_cell_walls <= cur_instr.walls;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
            req_valid <= nxt_valid;
         end
      end
   end

   // Receiver stall pattern, with one long hold-off to back the block up
   stall_mode_type stall_mode = STALL_NONE;
   int mode_left   = 0;
   int hold_left   = 0;
   int taken_words = 0;
   int stall_phase = 0;

   always @(posedge clock) begin : stall_proc
      logic nxt_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) taken_words++;
         nxt_stall = 1'b0;
         if (hold_left > 0) begin
            hold_left--;
            nxt_stall = 1'b1;
         end else if (!hold_done && taken_words >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            nxt_stall = 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            stall_phase++;
            case (stall_mode)
               STALL_NONE:  nxt_stall = 1'b0;
               STALL_COIN:  nxt_stall = 1'($urandom_range(0, 1));
               STALL_THIRD: nxt_stall = (stall_phase % 3 == 0);
               default:     nxt_stall = ($urandom_range(0, 7) == 0);
            endcase
         end
         rsp_stall <= nxt_stall;
      end
   end

   // Monitor: every accepted word against the oldest prediction
   always @(posedge clock) begin : check_proc
      robot_word_type exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_words.size() == 0) begin
            report_error("result word with nothing expected");
         end else begin
            exp_w = expected_words.pop_front();
            status_seen[exp_w.status]++;
            check_field("status", 16'(rsp_status), 16'(exp_w.status));
            check_field("robot_row", 16'(rsp_robot_row), 16'(exp_w.row));
            check_field("robot_col", 16'(rsp_robot_col), 16'(exp_w.col));
            check_field("heading", 16'(rsp_heading), 16'(exp_w.heading));
            check_field("acc_bit", 16'(rsp_acc_bit), 16'(exp_w.acc));
            check_field("loop_count", rsp_loop_count, exp_w.count);
            check_field("prog_counter", 16'(rsp_prog_counter), 16'(exp_w.pc));
         end
      end
   end

   task automatic add_instr(input logic [CMD_W-1:0] cmd, input logic signed [7:0] offset,
                            input logic [COUNT_W-1:0] count, input logic [2:0] row,
                            input logic [2:0] col, input logic [3:0] walls);
      instr_word_type w;
      w.cmd    = cmd;
      w.offset = offset;
      w.count  = count;
      w.row    = row;
      w.col    = col;
      w.walls  = walls;
      pending_instrs.push_back(w);
   endtask

   // Unused fields carry random values
   task automatic add_op(input logic [CMD_W-1:0] cmd);
      add_instr(cmd, 8'($urandom), 16'($urandom), 3'($urandom), 3'($urandom),
                4'($urandom));
   endtask

   // Mostly short hops, sometimes the full offset range
   function automatic logic signed [7:0] rand_offset();
      if ($urandom_range(0, 3) == 0) return 8'($urandom);
      return 8'($urandom_range(0, 16) - 8);
   endfunction

   // Sparse walls so that most moves get through
   task automatic add_cell();
      logic [3:0] walls;
      walls = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'h0;
      add_instr(grsm_pkg::CMD_LOAD_CELL, 8'($urandom), 16'($urandom), 3'($urandom),
                3'($urandom), walls);
   endtask

   initial begin : stimulus
      int n, k, m;

      // Directed: edges, walls, empty stacks, jumps at both ends of range
      add_op(grsm_pkg::CMD_START);
      add_op(grsm_pkg::CMD_MOVE);                 // top edge
      add_op(grsm_pkg::CMD_FRONT_BLOCKED);
      add_op(grsm_pkg::CMD_TURN_LEFT);
      add_op(grsm_pkg::CMD_MOVE);                 // left edge
      add_op(grsm_pkg::CMD_TURN_LEFT);
      add_op(grsm_pkg::CMD_TURN_LEFT);            // now facing right
      add_instr(grsm_pkg::CMD_LOAD_CELL, 8'sd0, 16'h0000, 3'd0, 3'd1, 4'b0100);
      add_op(grsm_pkg::CMD_MOVE);                 // neighbour's left wall
      add_instr(grsm_pkg::CMD_LOAD_CELL, -8'sd1, 16'hFFFF, 3'd7, 3'd7, 4'hF);
      add_op(grsm_pkg::CMD_POP);
      add_op(grsm_pkg::CMD_AND);
      add_op(grsm_pkg::CMD_POPCOUNT);
      add_op(grsm_pkg::CMD_PUSH);
      add_op(grsm_pkg::CMD_OR);
      // acc set, no jump
      add_instr(grsm_pkg::CMD_JZ, 8'sd127, 16'h0000, 3'd0, 3'd0, 4'h0);
      add_op(grsm_pkg::CMD_NOT);
      // to 127
      add_instr(grsm_pkg::CMD_JZ, 8'sd127, 16'hFFFF, 3'd7, 3'd7, 4'hF);
      // below zero
      add_instr(grsm_pkg::CMD_JMP, -8'sd128, 16'h0000, 3'd0, 3'd0, 4'h0);
      // back to 0
      add_instr(grsm_pkg::CMD_JCE, -8'sd127, 16'h0000, 3'd0, 3'd0, 4'h0);
      add_op(grsm_pkg::CMD_INC);
      add_op(grsm_pkg::CMD_PUSHCOUNT);
      add_op(grsm_pkg::CMD_POPCOUNT);
      add_op(grsm_pkg::CMD_END);
      add_instr(5'd31, 8'sd0, 16'h0000, 3'd0, 3'd0, 4'h0);

      // Random sequences, mostly well-formed programs
      while (pending_instrs.size() < DIRECTED_MAX + RANDOM_ITEMS) begin
         case ($urandom_range(0, 11))
            0, 1, 2: begin
               n = $urandom_range(1, 5);
               repeat (n) add_cell();
               n = $urandom_range(4, 14);
               repeat (n) begin
                  case ($urandom_range(0, 4))
                     0, 1, 2: add_op(grsm_pkg::CMD_MOVE);
                     3:       add_op(grsm_pkg::CMD_TURN_LEFT);
                     default: add_op(grsm_pkg::CMD_FRONT_BLOCKED);
                  endcase
               end
            end
            3, 4: begin
               k = $urandom_range(0, 18);
               repeat (k) add_op(($urandom_range(0, 2) == 0) ? grsm_pkg::CMD_NOT
                                                             : grsm_pkg::CMD_PUSH);
               k = $urandom_range(0, 18);
               repeat (k) begin
                  case ($urandom_range(0, 4))
                     0:       add_op(grsm_pkg::CMD_POP);
                     1:       add_op(grsm_pkg::CMD_AND);
                     2:       add_op(grsm_pkg::CMD_OR);
                     3:       add_op(grsm_pkg::CMD_NOT);
                     default: add_op(grsm_pkg::CMD_JZ);
                  endcase
               end
            end
            5, 6: begin
               n = $urandom_range(0, 8);
               m = $urandom_range(0, 8);
               repeat (n) add_op(grsm_pkg::CMD_INC);
               repeat ($urandom_range(1, 4)) add_op(grsm_pkg::CMD_PUSHCOUNT);
               repeat (m) add_op(grsm_pkg::CMD_INC);
               add_instr(grsm_pkg::CMD_JCE, rand_offset(), 16'(m), 3'($urandom),
                         3'($urandom), 4'($urandom));
               repeat ($urandom_range(1, 5)) add_op(grsm_pkg::CMD_POPCOUNT);
               add_instr(grsm_pkg::CMD_JCE, rand_offset(), 16'(n), 3'($urandom),
                         3'($urandom), 4'($urandom));
            end
            7: begin
               n = $urandom_range(1, 6);
               repeat (n) begin
                  k = $urandom_range(0, 2);
                  add_instr((k == 0) ? grsm_pkg::CMD_JMP :
                            (k == 1) ? grsm_pkg::CMD_JZ : grsm_pkg::CMD_JCE,
                            rand_offset(),
                            ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3))
                                                        : 16'($urandom),
                            3'($urandom), 3'($urandom), 4'($urandom));
               end
            end
            8: add_op(($urandom_range(0, 2) == 0) ? grsm_pkg::CMD_START
                                                  : grsm_pkg::CMD_NOT);
            9: begin
               n = $urandom_range(1, 4);
               repeat (n) add_op(5'($urandom));
            end
            default: add_op(5'($urandom_range(1, 16)));
         endcase
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Drain: everything sent, every word back, then a few spare cycles
      while (pending_instrs.size() != 0 || req_valid) @(negedge clock);
      while (expected_words.size() != 0) @(negedge clock);
      repeat (4) @(posedge clock);

      $display("summary: %0d instructions, %0d words; ok %0d, blocked %0d, overflow %0d,",
               instrs_done, results_seen, status_seen[grsm_pkg::STAT_OK],
               status_seen[grsm_pkg::STAT_BLOCKED], status_seen[grsm_pkg::STAT_OVERFLOW]);
      $display("summary: underflow %0d, pc range %0d, long hold-off %s",
               status_seen[grsm_pkg::STAT_UNDERFLOW], status_seen[grsm_pkg::STAT_PC_RANGE],
               hold_done ? "done" : "missed");
      if (error_count == 0) begin
         $display("tb_grid_robot_stack_machine: clean");
      end else begin
         $display("tb_grid_robot_stack_machine: errors");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("tb_grid_robot_stack_machine: errors");
      $finish;
   end

endmodule
